>>> sv/rgb_to_cct_and_lux_core_defines.svh
// Assertion macros used by the checker of the colour temperature core
`ifndef RGB_TO_CCT_AND_LUX_CORE_DEFINES_SVH
`define RGB_TO_CCT_AND_LUX_CORE_DEFINES_SVH

// Same-cycle implication on the clock and reset of the enclosing module
`define RGBCCT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbcct: same-cycle check failed");

// Next-cycle implication on the clock and reset of the enclosing module
`define RGBCCT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbcct: next-cycle check failed");

`endif

>>> sv/rgbcct_pkg.sv
package rgbcct_pkg;

    localparam int FRAC_BITS_DEF = 20;
    localparam int CNT_W         = 16;
    localparam int PROD_W        = 48;

    // rows: Y, X+Y+Z, ratio numerator, ratio denominator; columns: red, green, blue
    localparam int ROW_Y   = 0;
    localparam int ROW_SUM = 1;
    localparam int ROW_NUM = 2;
    localparam int ROW_DEN = 3;

    localparam logic signed [31:0] MAT_COEF [4][3] = '{
        '{-32'sd32466,      32'sd157837,     -32'sd73191},
        '{-32'sd114950,     32'sd389834,     -32'sd112500},
        '{ 32'sd238814000,  32'sd254991120,  -32'sd582910000},
        '{ 32'sd111082900, -32'sd854058428,   32'sd522885000}
    };

    // lux = Y / 100000 = (Y >> 5) / 3125, reciprocal scaled by 2^40
    localparam logic [PROD_W-1:0] LUX_SAT_LIM = 48'd6553600000;
    localparam logic [28:0]       LUX_RECIP   = 29'd351843721;

    // kelvin = x / 100, reciprocal scaled by 2^32
    localparam logic [25:0] TEMP_RECIP = 26'd42949673;

    // cubic coefficients scaled by 100
    localparam logic [15:0] PC3 = 16'd44900;
    localparam logic [19:0] PC2 = 20'd352500;
    localparam logic [19:0] PC1 = 20'd682330;
    localparam logic [19:0] PC0 = 20'd552033;

    typedef struct packed {
        logic [CNT_W-1:0] lux;
        logic             invalid;
        logic             sat;
        logic             nneg;
    } side_t;

    typedef struct packed {
        logic             sat;
        logic             invalid;
        logic [CNT_W-1:0] lux;
        logic [CNT_W-1:0] temp;
    } out_t;

endpackage

>>> sv/rgbcct_matrix.sv
module rgbcct_matrix (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               ce,
    input  logic                               in_valid,
    input  logic [rgbcct_pkg::CNT_W-1:0]       red,
    input  logic [rgbcct_pkg::CNT_W-1:0]       green,
    input  logic [rgbcct_pkg::CNT_W-1:0]       blue,
    output logic                               out_valid,
    output logic [rgbcct_pkg::PROD_W-1:0]      un,
    output logic [rgbcct_pkg::PROD_W-1:0]      ud,
    output rgbcct_pkg::side_t                  side
);

    localparam int PW = rgbcct_pkg::PROD_W;
    localparam int CW = rgbcct_pkg::CNT_W;

    function automatic logic signed [PW-1:0] cmul(logic [CW-1:0] x, logic signed [31:0] c);
        logic signed [PW:0] p;
        p = $signed({1'b0, x}) * c;
        return p[PW-1:0];
    endfunction

    logic                 v_reg [5];
    logic [CW-1:0]        chan_reg [3];
    logic signed [PW-1:0] prod_reg [4][3];
    logic signed [PW-1:0] row_reg [4];
    logic [PW-1:0]        un_reg;
    logic [PW-1:0]        ud_reg;
    logic                 nneg_reg;
    logic                 inv_reg;
    logic                 lux_zero_reg;
    logic                 lux_big_reg;
    logic [56:0]          lux_prod_reg;
    logic [PW-1:0]        un4_reg;
    logic [PW-1:0]        ud4_reg;
    rgbcct_pkg::side_t    side_reg;

    logic signed [PW-1:0] cy;
    logic [27:0]          y5;
    logic [PW-1:0]        un_next;
    logic [PW-1:0]        ud_next;
    logic [PW+2:0]        ud8;
    rgbcct_pkg::side_t    side_next;

    assign cy      = row_reg[rgbcct_pkg::ROW_Y];
    assign y5      = cy[32:5];
    assign un_next = row_reg[rgbcct_pkg::ROW_NUM][PW-1] ? PW'(-row_reg[rgbcct_pkg::ROW_NUM])
                                                        : PW'(row_reg[rgbcct_pkg::ROW_NUM]);
    assign ud_next = row_reg[rgbcct_pkg::ROW_DEN][PW-1] ? PW'(-row_reg[rgbcct_pkg::ROW_DEN])
                                                        : PW'(row_reg[rgbcct_pkg::ROW_DEN]);
    assign ud8     = {ud_reg, 3'b000};

    always_comb
    begin
        side_next.nneg    = nneg_reg;
        side_next.invalid = inv_reg;
        side_next.sat     = !inv_reg && ((PW+3)'(un_reg) > ud8);
        if (lux_zero_reg)
        begin
            side_next.lux = '0;
        end
        else if (lux_big_reg)
        begin
            side_next.lux = '1;
        end
        else
        begin
            side_next.lux = lux_prod_reg[55:40];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (ce)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < 5; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            chan_reg[0] <= red;
            chan_reg[1] <= green;
            chan_reg[2] <= blue;
            for (int k = 0; k < 4; k++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[k][c] <= cmul(chan_reg[c], rgbcct_pkg::MAT_COEF[k][c]);
                end
                row_reg[k] <= prod_reg[k][0] + prod_reg[k][1] + prod_reg[k][2];
            end
            un_reg       <= un_next;
            ud_reg       <= ud_next;
            nneg_reg     <= row_reg[rgbcct_pkg::ROW_NUM][PW-1] ^ row_reg[rgbcct_pkg::ROW_DEN][PW-1];
            inv_reg      <= (row_reg[rgbcct_pkg::ROW_SUM] == '0) ||
                            (row_reg[rgbcct_pkg::ROW_DEN] == '0);
            lux_zero_reg <= cy[PW-1] || (cy == '0);
            lux_big_reg  <= !cy[PW-1] && (PW'(cy) >= rgbcct_pkg::LUX_SAT_LIM);
            lux_prod_reg <= 57'(y5) * 57'(rgbcct_pkg::LUX_RECIP);
            un4_reg      <= un_reg;
            ud4_reg      <= ud_reg;
            side_reg     <= side_next;
        end
    end

    assign out_valid = v_reg[4];
    assign un        = un4_reg;
    assign ud        = ud4_reg;
    assign side      = side_reg;

endmodule

>>> sv/rgbcct_div.sv
module rgbcct_div #(
    parameter int FRAC_BITS = rgbcct_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          ce,
    input  logic                          in_valid,
    input  logic [rgbcct_pkg::PROD_W-1:0] un,
    input  logic [rgbcct_pkg::PROD_W-1:0] ud,
    input  rgbcct_pkg::side_t             side_in,
    output logic                          out_valid,
    output logic [FRAC_BITS+3:0]          nmag,
    output rgbcct_pkg::side_t             side_out
);

    localparam int QW = FRAC_BITS + 4;
    localparam int DW = rgbcct_pkg::PROD_W;
    localparam int RW = DW + 4;
    localparam logic [QW-1:0] N_SAT = {4'b1000, {FRAC_BITS{1'b0}}};

    logic              v_reg    [QW];
    logic [RW-1:0]     rem_reg  [QW];
    logic [QW-1:0]     q_reg    [QW];
    logic [DW-1:0]     ud_reg   [QW];
    rgbcct_pkg::side_t side_reg [QW];

    for (genvar j = 0; j < QW; j++)
    begin : g_step
        logic              v_in;
        logic [RW-1:0]     rem_in;
        logic [QW-1:0]     q_in;
        logic [DW-1:0]     ud_in;
        rgbcct_pkg::side_t side_s;
        logic [RW-1:0]     dsh;
        logic              ge;
        logic [RW-1:0]     rem_next;
        logic [QW-1:0]     q_next;

        if (j == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign rem_in = RW'(un);
            assign q_in   = '0;
            assign ud_in  = ud;
            assign side_s = side_in;
        end
        else
        begin : g_rest
            assign v_in   = v_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign ud_in  = ud_reg[j-1];
            assign side_s = side_reg[j-1];
        end

        assign dsh      = RW'(ud_in) << 3;
        assign ge       = rem_in >= dsh;
        assign rem_next = (ge ? rem_in - dsh : rem_in) << 1;
        assign q_next   = {q_in[QW-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[j] <= 1'b0;
            end
            else if (ce)
            begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg[j]  <= rem_next;
                q_reg[j]    <= q_next;
                ud_reg[j]   <= ud_in;
                side_reg[j] <= side_s;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign side_out  = side_reg[QW-1];
    assign nmag      = (side_reg[QW-1].invalid || side_reg[QW-1].sat) ? N_SAT : q_reg[QW-1];

endmodule

>>> sv/rgbcct_mfrac.sv
module rgbcct_mfrac #(
    parameter int          FRAC_BITS = rgbcct_pkg::FRAC_BITS_DEF,
    parameter int          AW        = FRAC_BITS + 21,
    parameter int          OW        = FRAC_BITS + 24,
    parameter logic [19:0] C         = rgbcct_pkg::PC1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 ce,
    input  logic                 in_valid,
    input  logic signed [AW-1:0] acc_in,
    input  logic [FRAC_BITS+3:0] nmag_in,
    input  rgbcct_pkg::side_t    side_in,
    output logic                 out_valid,
    output logic signed [OW-1:0] acc_out,
    output logic [FRAC_BITS+3:0] nmag_out,
    output rgbcct_pkg::side_t    side_out
);

    localparam int QW = FRAC_BITS + 4;
    localparam int MW = AW;
    localparam int LW = MW / 2;
    localparam int HW = MW - LW;
    localparam int FW = MW + QW;

    logic              v_reg    [4];
    logic [QW-1:0]     nmag_reg [4];
    rgbcct_pkg::side_t side_reg [4];
    logic              sgn_reg  [3];
    logic [MW-1:0]     mag_reg;
    logic [LW+QW-1:0]  plo_reg;
    logic [HW+QW-1:0]  phi_reg;
    logic [OW-2:0]     r_reg;
    logic signed [OW-1:0] acc_reg;

    logic [MW-1:0]        mag_next;
    logic [FW-1:0]        full;
    logic [FW-1:0]        shifted;
    logic signed [OW-1:0] cterm;
    logic signed [OW-1:0] rext;
    logic signed [OW-1:0] acc_next;

    assign mag_next = acc_in[AW-1] ? MW'(-acc_in) : MW'(acc_in);
    assign full     = (FW'(phi_reg) << LW) + FW'(plo_reg);
    assign shifted  = full >> FRAC_BITS;
    assign cterm    = $signed(OW'(C) << FRAC_BITS);
    assign rext     = $signed(OW'(r_reg));
    assign acc_next = sgn_reg[2] ? cterm - rext : cterm + rext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (ce)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < 4; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            nmag_reg[0] <= nmag_in;
            side_reg[0] <= side_in;
            sgn_reg[0]  <= acc_in[AW-1] ^ side_in.nneg;
            for (int i = 1; i < 4; i++)
            begin
                nmag_reg[i] <= nmag_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
            for (int i = 1; i < 3; i++)
            begin
                sgn_reg[i] <= sgn_reg[i-1];
            end
            mag_reg <= mag_next;
            plo_reg <= (LW+QW)'(mag_reg[LW-1:0]) * (LW+QW)'(nmag_reg[0]);
            phi_reg <= (HW+QW)'(mag_reg[MW-1:LW]) * (HW+QW)'(nmag_reg[0]);
            r_reg   <= shifted[OW-2:0];
            acc_reg <= acc_next;
        end
    end

    assign out_valid = v_reg[3];
    assign acc_out   = acc_reg;
    assign nmag_out  = nmag_reg[3];
    assign side_out  = side_reg[3];

endmodule

>>> sv/rgbcct_poly.sv
module rgbcct_poly #(
    parameter int FRAC_BITS = rgbcct_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 ce,
    input  logic                 in_valid,
    input  logic [FRAC_BITS+3:0] nmag,
    input  rgbcct_pkg::side_t    side_in,
    output logic                 out_valid,
    output rgbcct_pkg::out_t     result
);

    localparam int QW  = FRAC_BITS + 4;
    localparam int A1W = FRAC_BITS + 21;
    localparam int A2W = FRAC_BITS + 24;
    localparam int A3W = FRAC_BITS + 27;

    logic              v0_reg;
    logic              v1_reg;
    logic [QW+15:0]    p3_reg;
    logic [QW-1:0]     nmag0_reg;
    logic [QW-1:0]     nmag1_reg;
    rgbcct_pkg::side_t side0_reg;
    rgbcct_pkg::side_t side1_reg;
    logic signed [A1W-1:0] acc1_reg;

    logic signed [A1W-1:0] c2;
    logic signed [A1W-1:0] p3e;
    logic signed [A1W-1:0] acc1_next;

    logic                  m1_valid;
    logic signed [A2W-1:0] acc2;
    logic [QW-1:0]         nmag2;
    rgbcct_pkg::side_t     side2;
    logic                  m2_valid;
    logic signed [A3W-1:0] acc3;
    logic [QW-1:0]         nmag3;
    rgbcct_pkg::side_t     side3;

    logic              fv_reg [3];
    rgbcct_pkg::side_t fside_reg [2];
    logic              fneg_reg [2];
    logic [25:0]       x_reg;
    logic [51:0]       tprod_reg;
    rgbcct_pkg::out_t  res_reg;

    logic [A3W-1:0]    mag3;
    logic [19:0]       quo;
    rgbcct_pkg::out_t  res_next;

    assign c2        = $signed(A1W'(rgbcct_pkg::PC2) << FRAC_BITS);
    assign p3e       = $signed(A1W'(p3_reg));
    assign acc1_next = side0_reg.nneg ? c2 - p3e : c2 + p3e;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                fv_reg[i] <= 1'b0;
            end
        end
        else if (ce)
        begin
            v0_reg    <= in_valid;
            v1_reg    <= v0_reg;
            fv_reg[0] <= m2_valid;
            fv_reg[1] <= fv_reg[0];
            fv_reg[2] <= fv_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p3_reg    <= (QW+16)'(rgbcct_pkg::PC3) * (QW+16)'(nmag);
            nmag0_reg <= nmag;
            side0_reg <= side_in;
            acc1_reg  <= acc1_next;
            nmag1_reg <= nmag0_reg;
            side1_reg <= side0_reg;
        end
    end

    rgbcct_mfrac #(
        .FRAC_BITS (FRAC_BITS),
        .AW        (A1W),
        .OW        (A2W),
        .C         (rgbcct_pkg::PC1)
    ) u_mfrac1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (v1_reg),
        .acc_in    (acc1_reg),
        .nmag_in   (nmag1_reg),
        .side_in   (side1_reg),
        .out_valid (m1_valid),
        .acc_out   (acc2),
        .nmag_out  (nmag2),
        .side_out  (side2)
    );

    rgbcct_mfrac #(
        .FRAC_BITS (FRAC_BITS),
        .AW        (A2W),
        .OW        (A3W),
        .C         (rgbcct_pkg::PC0)
    ) u_mfrac2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (m1_valid),
        .acc_in    (acc2),
        .nmag_in   (nmag2),
        .side_in   (side2),
        .out_valid (m2_valid),
        .acc_out   (acc3),
        .nmag_out  (nmag3),
        .side_out  (side3)
    );

    assign mag3 = acc3[A3W-1] ? A3W'(-acc3) : A3W'(acc3);
    assign quo  = tprod_reg[51:32];

    always_comb
    begin
        res_next.lux     = fside_reg[1].lux;
        res_next.invalid = fside_reg[1].invalid;
        res_next.sat     = fside_reg[1].sat;
        res_next.temp    = quo[15:0];
        if (fside_reg[1].invalid)
        begin
            res_next.temp = '0;
            res_next.sat  = 1'b0;
        end
        else if (fneg_reg[1])
        begin
            res_next.temp = '0;
            if (quo != '0)
            begin
                res_next.sat = 1'b1;
            end
        end
        else if (quo[19:16] != '0)
        begin
            res_next.temp = '1;
            res_next.sat  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            x_reg        <= mag3[FRAC_BITS+25:FRAC_BITS];
            fneg_reg[0]  <= acc3[A3W-1];
            fside_reg[0] <= side3;
            tprod_reg    <= 52'(x_reg) * 52'(rgbcct_pkg::TEMP_RECIP);
            fneg_reg[1]  <= fneg_reg[0];
            fside_reg[1] <= fside_reg[0];
            res_reg      <= res_next;
        end
    end

    assign out_valid = fv_reg[2];
    assign result    = res_reg;

endmodule

>>> sv/rgb_to_cct_and_lux_core.sv
// Colour temperature and illuminance from one red, green, blue count triple per item.
// Counts go through a fixed 4x3 matrix to Y, X+Y+Z and the numerator and denominator of
// the McCamy ratio, formed as a fixed-point quotient with FRAC_BITS fraction bits and fed
// to the cubic; Y gives lux. One item is accepted every cycle while s_axis_tready is high.
// The divider, which resolves one quotient bit per stage over FRAC_BITS + 4 stages, makes
// up most of the pipeline. A zero divisor or zero X+Y+Z sets temp_invalid with temperature
// 0; a ratio beyond +/-8 or a temperature outside 0..65535 sets temp_saturated. A two-entry
// output buffer decouples the two sides.
module rgb_to_cct_and_lux_core #(
    parameter int FRAC_BITS = rgbcct_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // red_count, green_count, blue_count
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // color_temp_kelvin, lux_value
    output logic [1:0]  m_axis_tuser   // temp_invalid, temp_saturated
);

    localparam int QW = FRAC_BITS + 4;
    localparam int PW = rgbcct_pkg::PROD_W;

    logic              ce;
    logic              mx_valid;
    logic [PW-1:0]     un;
    logic [PW-1:0]     ud;
    rgbcct_pkg::side_t mx_side;
    logic              dv_valid;
    logic [QW-1:0]     nmag;
    rgbcct_pkg::side_t dv_side;
    logic              pv;
    rgbcct_pkg::out_t  pd;

    logic              out_valid_reg;
    logic              out_valid_next;
    rgbcct_pkg::out_t  out_data_reg;
    rgbcct_pkg::out_t  out_data_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    rgbcct_pkg::out_t  skid_data_reg;
    rgbcct_pkg::out_t  skid_data_next;
    logic              out_free;

    assign ce            = !skid_valid_reg;
    assign s_axis_tready = ce;

    rgbcct_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s_axis_tvalid),
        .red       (s_axis_tdata[15:0]),
        .green     (s_axis_tdata[31:16]),
        .blue      (s_axis_tdata[47:32]),
        .out_valid (mx_valid),
        .un        (un),
        .ud        (ud),
        .side      (mx_side)
    );

    rgbcct_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (mx_valid),
        .un        (un),
        .ud        (ud),
        .side_in   (mx_side),
        .out_valid (dv_valid),
        .nmag      (nmag),
        .side_out  (dv_side)
    );

    rgbcct_poly #(
        .FRAC_BITS (FRAC_BITS)
    ) u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (dv_valid),
        .nmag      (nmag),
        .side_in   (dv_side),
        .out_valid (pv),
        .result    (pd)
    );

    always_comb
    begin
        out_free        = !out_valid_reg || m_axis_tready;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = pv;
                out_data_next  = pd;
            end
        end
        else if (pv && ce)
        begin
            // hold the output, park the item
            skid_valid_next = 1'b1;
            skid_data_next  = pd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg.lux, out_data_reg.temp};
    assign m_axis_tuser  = {out_data_reg.sat, out_data_reg.invalid};

endmodule

>>> sv/rgbcct_check.sv
`include "rgb_to_cct_and_lux_core_defines.svh"

module rgbcct_check (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    `RGBCCT_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    `RGBCCT_ASSERT_IMP(a_invalid_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[15:0] == 16'd0 && !m_axis_tuser[1])

    `RGBCCT_ASSERT_NXT(a_stall_keeps, !s_axis_tready && !m_axis_tready, !s_axis_tready)

    `RGBCCT_ASSERT_IMP(a_fill_on_stall, $fell(s_axis_tready), $past(m_axis_tvalid && !m_axis_tready))

endmodule

bind rgb_to_cct_and_lux_core rgbcct_check u_rgbcct_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
